// ===== design/tkrc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tkrc_pkg;

  localparam int SET_INDEX_BITS = 13;
  localparam int NUM_SETS       = 1 << SET_INDEX_BITS;
  localparam int AGE_BITS       = 16;

  localparam logic [63:0] HASH_MUL_A = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] HASH_MUL_B = 64'hC2B2_AE3D_27D4_EB4F;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_STORE  = 1'b1;

  typedef logic [SET_INDEX_BITS-1:0] set_idx_t;
  typedef logic [AGE_BITS-1:0]       age_t;

  typedef struct packed {
    logic [63:0]        tag_white;
    logic [63:0]        tag_black;
    logic signed [31:0] data_mid;
    logic signed [31:0] data_end;
  } entry_t;

  // per-set replacement info, both ways
  typedef struct packed {
    logic valid1;
    age_t age1;
    logic valid0;
    age_t age0;
  } meta_t;

  typedef struct packed {
    logic     load_in;
    logic     rd_en;
    logic     commit;
    logic     out_load;
    logic     clr_wr;
    set_idx_t clr_addr;
  } cmd_t;

  typedef struct packed {
    logic op_store;
  } status_t;

  // Only the low index bits of each 64-bit product matter, so the low
  // operand bits are enough.
  function automatic set_idx_t set_hash(input logic [63:0] kw, input logic [63:0] kb);
    set_idx_t pa;
    set_idx_t pb;
    pa = kw[SET_INDEX_BITS-1:0] * HASH_MUL_A[SET_INDEX_BITS-1:0];
    pb = kb[SET_INDEX_BITS-1:0] * HASH_MUL_B[SET_INDEX_BITS-1:0];
    return pa ^ pb;
  endfunction

endpackage

`default_nettype wire

// ===== design/tkrc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tkrc_ctrl
  import tkrc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_RESOLVE
  } state_t;

  state_t   state_r, state_nxt;
  set_idx_t clr_cnt_r, clr_cnt_nxt;
  logic     out_valid_r, out_valid_nxt;
  logic     out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.clr_addr  = clr_cnt_r;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr  = 1'b1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == set_idx_t'(NUM_SETS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_RESOLVE;
      end
      ST_RESOLVE: begin
        if (status.op_store) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end else if (out_free) begin
          // lookup waits here until the output register can take the result
          cmd.commit    = 1'b1;
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/tkrc_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tkrc_dp
  import tkrc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_opcode,
  input  wire logic [63:0]        in_key_white,
  input  wire logic [63:0]        in_key_black,
  input  wire logic signed [31:0] in_value_mid,
  input  wire logic signed [31:0] in_value_end,
  output logic                    out_hit,
  output logic signed [31:0]      out_found_mid,
  output logic signed [31:0]      out_found_end,
  input  wire cmd_t               cmd,
  output status_t                 status
);

  // transaction registers
  logic               op_r;
  logic [63:0]        kw_r;
  logic [63:0]        kb_r;
  logic signed [31:0] vm_r;
  logic signed [31:0] ve_r;
  set_idx_t           idx_r;

  entry_t way0_mem [NUM_SETS];
  entry_t way1_mem [NUM_SETS];
  meta_t  meta_mem [NUM_SETS];

  entry_t rd0_r;
  entry_t rd1_r;
  meta_t  meta_rd_r;

  age_t age_r, age_nxt;

  logic   hit0, hit1, hit, victim1;
  entry_t hit_entry;
  entry_t wr_entry;
  logic   wr0_en, wr1_en;
  logic   meta_we;
  set_idx_t meta_waddr;
  meta_t  meta_upd, meta_wdata;
  logic   hit_out_r;
  logic signed [31:0] found_mid_r, found_end_r;

  assign status.op_store = (op_r == OP_STORE);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r  <= in_opcode;
      kw_r  <= in_key_white;
      kb_r  <= in_key_black;
      vm_r  <= in_value_mid;
      ve_r  <= in_value_end;
      idx_r <= set_hash(in_key_white, in_key_black);
    end
  end

  always_comb begin
    hit0      = meta_rd_r.valid0 && rd0_r.tag_white == kw_r && rd0_r.tag_black == kb_r;
    hit1      = meta_rd_r.valid1 && rd1_r.tag_white == kw_r && rd1_r.tag_black == kb_r;
    hit       = hit0 || hit1;
    hit_entry = hit0 ? rd0_r : rd1_r;
    // plain unsigned age compare, no wrap correction
    victim1   = !meta_rd_r.valid1 || (meta_rd_r.age1 < meta_rd_r.age0);
    age_nxt   = age_r + 1'b1;

    wr_entry.tag_white = kw_r;
    wr_entry.tag_black = kb_r;
    wr_entry.data_mid  = vm_r;
    wr_entry.data_end  = ve_r;

    wr0_en = cmd.commit && status.op_store && !victim1;
    wr1_en = cmd.commit && status.op_store && victim1;

    meta_upd = meta_rd_r;
    if (status.op_store ? victim1 : !hit0) begin
      meta_upd.valid1 = 1'b1;
      meta_upd.age1   = age_nxt;
    end else begin
      meta_upd.valid0 = 1'b1;
      meta_upd.age0   = age_nxt;
    end

    if (cmd.clr_wr) begin
      meta_we    = 1'b1;
      meta_waddr = cmd.clr_addr;
      meta_wdata = '0;
    end else begin
      meta_we    = cmd.commit && (status.op_store || hit);
      meta_waddr = idx_r;
      meta_wdata = meta_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (wr0_en) begin
      way0_mem[idx_r] <= wr_entry;
    end
    if (cmd.rd_en) begin
      rd0_r <= way0_mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (wr1_en) begin
      way1_mem[idx_r] <= wr_entry;
    end
    if (cmd.rd_en) begin
      rd1_r <= way1_mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    if (cmd.rd_en) begin
      meta_rd_r <= meta_mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      age_r <= '0;
    end else if (cmd.commit && (status.op_store || hit)) begin
      age_r <= age_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      hit_out_r   <= hit;
      found_mid_r <= hit ? hit_entry.data_mid : 32'sd0;
      found_end_r <= hit ? hit_entry.data_end : 32'sd0;
    end
  end

  assign out_hit       = hit_out_r;
  assign out_found_mid = found_mid_r;
  assign out_found_end = found_end_r;

endmodule

`default_nettype wire

// ===== design/two_way_keyed_result_cache.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Two-way set-associative result cache keyed by two 64-bit words, 8192 sets.
// Each input transaction (lookup or store) goes through accept, set RAM read,
// then compare and write back; the next transaction can be accepted in the
// cycle after that, so no new transaction is taken before the last one is
// through, set by the single read-modify-write pass through the set RAMs. A
// lookup returns one result transaction through an output register; a store
// returns none. A lookup whose result register is still occupied waits in
// the compare step until the result is taken. After reset the block runs a
// clearing pass over all 8192 sets of the valid/age RAM, with in_ready low.

module two_way_keyed_result_cache
  import tkrc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_opcode,
  input  wire logic [63:0]        in_key_white,
  input  wire logic [63:0]        in_key_black,
  input  wire logic signed [31:0] in_value_mid,
  input  wire logic signed [31:0] in_value_end,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_hit,
  output logic signed [31:0]      out_found_mid,
  output logic signed [31:0]      out_found_end
);

  cmd_t    cmd;
  status_t status;

  tkrc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  tkrc_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_opcode     (in_opcode),
    .in_key_white  (in_key_white),
    .in_key_black  (in_key_black),
    .in_value_mid  (in_value_mid),
    .in_value_end  (in_value_end),
    .out_hit       (out_hit),
    .out_found_mid (out_found_mid),
    .out_found_end (out_found_end),
    .cmd           (cmd),
    .status        (status)
  );

  a_store_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !status.op_store)
    else $error("result produced for a store");

  a_out_reg_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result register overwritten");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_wr |-> !in_ready)
    else $error("input accepted during clearing pass");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (!in_ready && cmd.rd_en))
    else $error("accepted transaction not followed by set read");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import tkrc_pkg::*;

  localparam int HOT_SETS     = 6;
  localparam int KEYS_PER_SET = 5;
  localparam int RANDOM_ITEMS = 1730;
  localparam int DRAIN_CYCLES = 20;

  localparam logic signed [31:0] SCORE_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] SCORE_MAX = 32'sh7FFF_FFFF;

  typedef struct {
    logic               op;
    logic [63:0]        kw;
    logic [63:0]        kb;
    logic signed [31:0] vm;
    logic signed [31:0] ve;
  } cache_req_t;

  typedef struct {
    logic               hit;
    logic signed [31:0] found_mid;
    logic signed [31:0] found_end;
  } lookup_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_opcode = OP_LOOKUP;
  logic [63:0]        in_key_white = '0;
  logic [63:0]        in_key_black = '0;
  logic signed [31:0] in_value_mid = '0;
  logic signed [31:0] in_value_end = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_hit;
  logic signed [31:0] out_found_mid;
  logic signed [31:0] out_found_end;

  cache_req_t     req_pending[$];
  lookup_result_t results_due[$];
  cache_req_t     cur_req;

  // shadow copy of the cache contents
  logic [63:0]        sh_tag_white[2*NUM_SETS];
  logic [63:0]        sh_tag_black[2*NUM_SETS];
  logic signed [31:0] sh_mid[2*NUM_SETS];
  logic signed [31:0] sh_end[2*NUM_SETS];
  bit                 sh_valid[2*NUM_SETS];
  bit [15:0]          sh_age[2*NUM_SETS];
  bit [15:0]          sh_stamp;

  int   error_count = 0;
  logic in_fire = 1'b0;
  int   gap_left = 0;
  int   burst_left = 1;
  int   pat_tick = 0;
  logic [15:0] ready_pat = '1;

  two_way_keyed_result_cache u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_opcode    (in_opcode),
    .in_key_white (in_key_white),
    .in_key_black (in_key_black),
    .in_value_mid (in_value_mid),
    .in_value_end (in_value_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_hit      (out_hit),
    .out_found_mid(out_found_mid),
    .out_found_end(out_found_end)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic set_idx_t set_of_keys(input logic [63:0] kw, input logic [63:0] kb);
    logic [63:0] h;
    h = (kw * HASH_MUL_A) ^ (kb * HASH_MUL_B);
    return h[SET_INDEX_BITS-1:0];
  endfunction

  // Second key word that lands (kw, kb) in the given set; upper bits random.
  function automatic logic [63:0] key_in_set(input set_idx_t set_no, input logic [63:0] kw);
    logic [63:0] inv;
    logic [63:0] t;
    logic [63:0] kb;
    inv = HASH_MUL_B;
    repeat (6) inv = inv * (64'd2 - HASH_MUL_B * inv);
    t = ({{(64-SET_INDEX_BITS){1'b0}}, set_no} ^ (kw * HASH_MUL_A)) * inv;
    kb = {$urandom, $urandom};
    kb[SET_INDEX_BITS-1:0] = t[SET_INDEX_BITS-1:0];
    return kb;
  endfunction

  function automatic logic signed [31:0] score_value();
    case ($urandom_range(0, 15))
      0:       return SCORE_MIN;
      1:       return SCORE_MAX;
      2:       return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic cache_req_t make_req(input logic op, input logic [63:0] kw,
                                          input logic [63:0] kb,
                                          input logic signed [31:0] vm,
                                          input logic signed [31:0] ve);
    cache_req_t r;
    r.op = op;
    r.kw = kw;
    r.kb = kb;
    r.vm = vm;
    r.ve = ve;
    return r;
  endfunction

  task automatic apply_cache_op(input cache_req_t r);
    int             base;
    int             victim;
    lookup_result_t res;
    base = 2 * set_of_keys(r.kw, r.kb);
    if (r.op == OP_LOOKUP) begin
      res.hit = 1'b0;
      res.found_mid = '0;
      res.found_end = '0;
      for (int w = 0; w < 2; w++) begin
        if (!res.hit && sh_valid[base+w] && sh_tag_white[base+w] == r.kw &&
            sh_tag_black[base+w] == r.kb) begin
          sh_stamp++;
          sh_age[base+w] = sh_stamp;
          res.hit = 1'b1;
          res.found_mid = sh_mid[base+w];
          res.found_end = sh_end[base+w];
        end
      end
      results_due.push_back(res);
    end else begin
      sh_stamp++;
      // way 1 only if empty or strictly older; no wrap correction on ages
      victim = (!sh_valid[base+1] || sh_age[base+1] < sh_age[base]) ? base + 1 : base;
      sh_tag_white[victim] = r.kw;
      sh_tag_black[victim] = r.kb;
      sh_mid[victim] = r.vm;
      sh_end[victim] = r.ve;
      sh_valid[victim] = 1'b1;
      sh_age[victim] = sh_stamp;
    end
  endtask

  task automatic compare_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // monitor and predictor, both on the rising edge
  always @(posedge clk) begin : monitor
    lookup_result_t want;
    in_fire <= in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result transaction: hit=%0d mid=%0d end=%0d",
                   $time, out_hit, out_found_mid, out_found_end);
          error_count++;
        end else begin
          want = results_due.pop_front();
          compare_field("hit", 32'(want.hit), 32'(out_hit));
          compare_field("found_mid", want.found_mid, out_found_mid);
          compare_field("found_end", want.found_end, out_found_end);
        end
      end
      if (in_valid && in_ready) apply_cache_op(cur_req);
    end
  end

  // driver and receiver stall pattern, on the falling edge
  always @(negedge clk) begin : driver
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_fire) begin
        if (gap_left > 0 || req_pending.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          cur_req = req_pending.pop_front();
          in_opcode <= cur_req.op;
          in_key_white <= cur_req.kw;
          in_key_black <= cur_req.kb;
          in_value_mid <= cur_req.vm;
          in_value_end <= cur_req.ve;
          in_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 48 : 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
      if (pat_tick == 0) begin
        case ($urandom_range(0, 3))
          0:       ready_pat = 16'hFFFF;
          1:       ready_pat = 16'($urandom);
          2:       ready_pat = 16'($urandom | $urandom);
          default: ready_pat = 16'($urandom & $urandom) | 16'h1;
        endcase
        pat_tick = 64;
      end
      pat_tick--;
      out_ready <= ready_pat[0];
      ready_pat = {ready_pat[0], ready_pat[15:1]};
    end
  end

  initial begin : stimulus
    logic [63:0] set_kw[3];
    logic [63:0] set_kb[3];
    logic [63:0] dup_kw;
    logic [63:0] dup_kb;
    logic [63:0] pool_kw[HOT_SETS*KEYS_PER_SET];
    logic [63:0] pool_kb[HOT_SETS*KEYS_PER_SET];
    logic [63:0] kw;
    logic [63:0] kb;
    set_idx_t    hot;
    int          sel;
    int          k;
    int          bitpos;
    logic        op;

    rst_n = 1'b0;
    for (int i = 0; i < 3; i++) begin
      set_kw[i] = {$urandom, $urandom};
      set_kb[i] = key_in_set(set_idx_t'(5), set_kw[i]);
    end
    dup_kw = {$urandom, $urandom};
    dup_kb = key_in_set(set_idx_t'(9), dup_kw);

    // directed: empty miss, key and score extremes
    req_pending.push_back(make_req(OP_LOOKUP, '0, '0, '0, '0));
    req_pending.push_back(make_req(OP_STORE, '0, '0, SCORE_MIN, SCORE_MAX));
    req_pending.push_back(make_req(OP_LOOKUP, '0, '0, '0, '0));
    req_pending.push_back(make_req(OP_STORE, '1, '1, SCORE_MAX, SCORE_MIN));
    req_pending.push_back(make_req(OP_LOOKUP, '1, '1, '1, '1));
    req_pending.push_back(make_req(OP_LOOKUP, '0, '1, '0, '0));
    // one set, three keys: invalid way 1 first, then way 0 while still empty,
    // then eviction of the older way
    for (int i = 0; i < 3; i++)
      req_pending.push_back(make_req(OP_STORE, set_kw[i], set_kb[i], score_value(),
                                     score_value()));
    for (int i = 0; i < 3; i++)
      req_pending.push_back(make_req(OP_LOOKUP, set_kw[i], set_kb[i], '0, '0));
    req_pending.push_back(make_req(OP_STORE, set_kw[0], set_kb[0], score_value(),
                                   score_value()));
    req_pending.push_back(make_req(OP_LOOKUP, set_kw[1], set_kb[1], '0, '0));
    req_pending.push_back(make_req(OP_LOOKUP, set_kw[0], set_kb[0], '0, '0));
    // same key in both ways: way 0 copy must win
    req_pending.push_back(make_req(OP_STORE, dup_kw, dup_kb, 32'sd11, -32'sd11));
    req_pending.push_back(make_req(OP_STORE, dup_kw, dup_kb, -32'sd22, 32'sd22));
    req_pending.push_back(make_req(OP_LOOKUP, dup_kw, dup_kb, '0, '0));
    // same set, one tag word differs in an upper bit
    req_pending.push_back(make_req(OP_LOOKUP, set_kw[0], set_kb[0] ^ (64'd1 << 63), '0,
                                   '0));
    req_pending.push_back(make_req(OP_LOOKUP, set_kw[0] ^ (64'd1 << 40), set_kb[0], '0,
                                   '0));

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // random part: small key pools on a few sets so that ways get evicted,
    // plus fully random keys and near misses
    for (int s = 0; s < HOT_SETS; s++) begin
      hot = set_idx_t'($urandom);
      for (int j = 0; j < KEYS_PER_SET; j++) begin
        pool_kw[s*KEYS_PER_SET+j] = {$urandom, $urandom};
        pool_kb[s*KEYS_PER_SET+j] = key_in_set(hot, pool_kw[s*KEYS_PER_SET+j]);
      end
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      sel = $urandom_range(0, 9);
      k = $urandom_range(0, HOT_SETS * KEYS_PER_SET - 1);
      kw = pool_kw[k];
      kb = pool_kb[k];
      if (sel == 0) begin
        kw = {$urandom, $urandom};
        kb = {$urandom, $urandom};
      end else if (sel == 1) begin
        bitpos = $urandom_range(0, 63);
        if ($urandom_range(0, 1)) kw[bitpos] = ~kw[bitpos];
        else kb[bitpos] = ~kb[bitpos];
      end
      op = ($urandom_range(0, 99) < 45) ? OP_STORE : OP_LOOKUP;
      req_pending.push_back(make_req(op, kw, kb, score_value(), score_value()));
    end

    wait (req_pending.size() == 0 && !in_valid && results_due.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #50_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== two_way_keyed_result_cache.f =====
design/tkrc_pkg.sv
design/tkrc_ctrl.sv
design/tkrc_dp.sv
design/two_way_keyed_result_cache.sv
tb/sv/testbench.sv
